// ----- src/rrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Referenced range tracker package
// Shared constants, command and result codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package rrt_pkg;

	// Default table depth and cap on overlap results per query
	localparam int MAX_RANGES_DEF = 32;
	localparam int MAX_RESULTS    = 32;
	localparam int NRES_W         = $clog2(MAX_RESULTS + 1);

	// Field widths
	localparam int ADDR_W = 32;
	localparam int END_W  = 33;

	// Command codes
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_MARK  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	// Result kinds
	typedef enum logic [2:0] {
		K_CLEARED  = 3'd0,
		K_APPENDED = 3'd1,
		K_MERGED   = 3'd2,
		K_EMPTY    = 3'd3,
		K_OVERFLOW = 3'd4,
		K_OVERLAP  = 3'd5,
		K_NONE     = 3'd6,
		K_CONFLICT = 3'd7
	} kind_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_MARK  = 2'd1,
		S_SCAN  = 2'd2,
		S_FLUSH = 2'd3
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic  ld;         // capture transaction fields
		logic  rd_last;    // read last table entry
		logic  rd_first;   // read entry 0, restart scan
		logic  rd_next;    // read next scan entry
		logic  wr_merge;   // extend last entry
		logic  wr_append;  // append new entry
		logic  set_ovf;    // set sticky overflow
		logic  clr_tbl;    // empty the table
		logic  ovl_take;   // latch current intersection as pending
		logic  emit;       // drive a result next cycle
		kind_t emit_kind;
		logic  emit_last;
		logic  emit_pend;  // result carries the pending intersection
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] cmd;        // command on the input port
		logic       size_zero;  // size on the input port is zero
		logic       cnt_zero;
		logic       full;
		logic       ovf;
		logic       hit_merge;  // registered mark start lies in last entry
		logic       hit_ovl;    // scanned entry intersects query range
		logic       scan_last;  // scanned entry is the last one
		logic       res_cap;    // one more overlap reaches the result cap
		logic       pend_v;
	} sts_t;

endpackage

// ----- src/rrt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rrt_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/rrt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range tracker controller
// Sequences mark, query and clear transactions over the datapath.
// ----------------------------------------------------------------------------
module rrt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rrt_pkg::sts_t sts,
	output rrt_pkg::ctl_t ctl
);

	rrt_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		ctl           = '0;
		ctl.emit_kind = rrt_pkg::K_CLEARED;
		case (state_q)
			rrt_pkg::S_IDLE: begin
				if (start) begin
					ctl.ld = 1'b1;
					case (sts.cmd)
						rrt_pkg::CMD_CLEAR: begin
							ctl.clr_tbl   = 1'b1;
							ctl.emit      = 1'b1;
							ctl.emit_kind = rrt_pkg::K_CLEARED;
							ctl.emit_last = 1'b1;
						end
						rrt_pkg::CMD_MARK: begin
							if (sts.size_zero) begin
								ctl.emit      = 1'b1;
								ctl.emit_kind = rrt_pkg::K_EMPTY;
								ctl.emit_last = 1'b1;
							end else begin
								ctl.rd_last = 1'b1;
								state_d     = rrt_pkg::S_MARK;
							end
						end
						rrt_pkg::CMD_QUERY: begin
							if (sts.ovf) begin
								ctl.emit      = 1'b1;
								ctl.emit_kind = rrt_pkg::K_CONFLICT;
								ctl.emit_last = 1'b1;
							end else if (sts.cnt_zero) begin
								ctl.emit      = 1'b1;
								ctl.emit_kind = rrt_pkg::K_NONE;
								ctl.emit_last = 1'b1;
							end else begin
								ctl.rd_first = 1'b1;
								state_d      = rrt_pkg::S_SCAN;
							end
						end
						default: begin
							// unused code: no result
						end
					endcase
				end
			end
			rrt_pkg::S_MARK: begin
				ctl.emit      = 1'b1;
				ctl.emit_last = 1'b1;
				if (sts.hit_merge) begin
					ctl.wr_merge  = 1'b1;
					ctl.emit_kind = rrt_pkg::K_MERGED;
				end else if (sts.full) begin
					ctl.set_ovf   = 1'b1;
					ctl.emit_kind = rrt_pkg::K_OVERFLOW;
				end else begin
					ctl.wr_append = 1'b1;
					ctl.emit_kind = rrt_pkg::K_APPENDED;
				end
				state_d = rrt_pkg::S_IDLE;
			end
			rrt_pkg::S_SCAN: begin
				// a new hit pushes the older pending intersection out
				if (sts.hit_ovl) begin
					ctl.ovl_take = 1'b1;
					if (sts.pend_v) begin
						ctl.emit      = 1'b1;
						ctl.emit_kind = rrt_pkg::K_OVERLAP;
						ctl.emit_pend = 1'b1;
					end
				end
				if (sts.scan_last || (sts.hit_ovl && sts.res_cap)) begin
					state_d = rrt_pkg::S_FLUSH;
				end else begin
					ctl.rd_next = 1'b1;
				end
			end
			rrt_pkg::S_FLUSH: begin
				ctl.emit      = 1'b1;
				ctl.emit_last = 1'b1;
				if (sts.pend_v) begin
					ctl.emit_kind = rrt_pkg::K_OVERLAP;
					ctl.emit_pend = 1'b1;
				end else begin
					ctl.emit_kind = rrt_pkg::K_NONE;
				end
				state_d = rrt_pkg::S_IDLE;
			end
			default: begin
				state_d = rrt_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != rrt_pkg::S_IDLE);

	// Table writes only happen while evaluating a mark
	a_wr_in_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.wr_merge || ctl.wr_append || ctl.set_ovf) |-> state_q == rrt_pkg::S_MARK)
		else $error("table update outside mark evaluation");

	// A scan always ends in a flush that closes the transaction
	a_flush_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rrt_pkg::S_FLUSH |-> $past(state_q) == rrt_pkg::S_SCAN)
		else $error("flush not preceded by scan");

	// Scan is entered only through a query with a populated table
	a_scan_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrt_pkg::S_SCAN && $past(state_q) == rrt_pkg::S_IDLE)
		|-> $past(!sts.cnt_zero && !sts.ovf))
		else $error("scan started on empty or overflowed table");

endmodule

// ----- src/rrt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range tracker datapath
// Range table RAM, fill count, overflow flag, scan/intersection logic and
// result registers.
// ----------------------------------------------------------------------------
module rrt_dp #(
	parameter int MAX_RANGES = rrt_pkg::MAX_RANGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [1:0]                  cmd,
	input  logic [rrt_pkg::ADDR_W-1:0]  addr,
	input  logic [rrt_pkg::ADDR_W-1:0]  size,
	input  rrt_pkg::ctl_t               ctl,
	output rrt_pkg::sts_t               sts,
	output logic                        valid,
	output logic [2:0]                  kind,
	output logic [rrt_pkg::END_W-1:0]   range_start,
	output logic [rrt_pkg::END_W-1:0]   range_end,
	output logic                        last
);

	localparam int CNT_W  = $clog2(MAX_RANGES + 1);
	localparam int IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int A_W    = rrt_pkg::ADDR_W;
	localparam int E_W    = rrt_pkg::END_W;
	localparam int WORD_W = A_W + E_W;
	localparam int NR_W   = rrt_pkg::NRES_W;

	// Transaction fields
	logic [A_W-1:0]   addr_q;
	logic [E_W-1:0]   end_q;

	// Table control state
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic [NR_W-1:0]  nres_q;
	logic             pend_v_q;
	logic [E_W-1:0]   pend_s_q;
	logic [E_W-1:0]   pend_e_q;

	// Result registers
	logic             valid_q;
	logic [2:0]       kind_q;
	logic [E_W-1:0]   rs_q;
	logic [E_W-1:0]   re_q;
	logic             last_q;

	// RAM ports
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [WORD_W-1:0] wdata;
	logic              re;
	logic [IDX_W-1:0]  raddr;
	logic [WORD_W-1:0] rdata;
	logic [CNT_W-1:0]  cnt_m1;
	logic [A_W-1:0]    ent_s;
	logic [E_W-1:0]    ent_e;
	logic [E_W-1:0]    merge_e;
	logic [E_W-1:0]    ovl_s;
	logic [E_W-1:0]    ovl_e;

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign ent_s  = rdata[WORD_W-1:E_W];
	assign ent_e  = rdata[E_W-1:0];

	// Read address: last entry for marks, scan pointer for queries
	always_comb begin
		re    = ctl.rd_last || ctl.rd_first || ctl.rd_next;
		raddr = scan_idx_q[IDX_W-1:0];
		if (ctl.rd_last) begin
			raddr = cnt_m1[IDX_W-1:0];
		end else if (ctl.rd_first) begin
			raddr = '0;
		end
	end

	// Merge keeps the larger end; append writes a fresh entry
	assign merge_e = (end_q > ent_e) ? end_q : ent_e;

	always_comb begin
		we    = ctl.wr_merge || ctl.wr_append;
		waddr = cnt_q[IDX_W-1:0];
		wdata = {addr_q, end_q};
		if (ctl.wr_merge) begin
			waddr = cnt_m1[IDX_W-1:0];
			wdata = {ent_s, merge_e};
		end
	end

	rrt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_RANGES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Intersection of scanned entry with the query range
	assign ovl_s = (ent_s > addr_q) ? {1'b0, ent_s} : {1'b0, addr_q};
	assign ovl_e = (ent_e < end_q) ? ent_e : end_q;

	// Status
	always_comb begin
		sts           = '0;
		sts.cmd       = cmd;
		sts.size_zero = (size == '0);
		sts.cnt_zero  = (cnt_q == '0);
		sts.full      = (cnt_q == CNT_W'(MAX_RANGES));
		sts.ovf       = ovf_q;
		sts.hit_merge = (cnt_q != '0) && (addr_q >= ent_s) && ({1'b0, addr_q} <= ent_e);
		sts.hit_ovl   = (ovl_s < ovl_e);
		sts.scan_last = (scan_idx_q == cnt_q);
		sts.res_cap   = (nres_q == NR_W'(rrt_pkg::MAX_RESULTS - 1));
		sts.pend_v    = pend_v_q;
	end

	// Captured transaction fields
	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			addr_q <= addr;
			end_q  <= {1'b0, addr} + {1'b0, size};
		end
	end

	// Table count, overflow flag and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			scan_idx_q <= '0;
			nres_q     <= '0;
			pend_v_q   <= 1'b0;
		end else begin
			if (ctl.clr_tbl) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (ctl.wr_append) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctl.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (ctl.rd_first) begin
				scan_idx_q <= CNT_W'(1);
				nres_q     <= '0;
				pend_v_q   <= 1'b0;
			end else if (ctl.rd_next) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
			if (ctl.ovl_take) begin
				nres_q   <= nres_q + NR_W'(1);
				pend_v_q <= 1'b1;
			end
		end
	end

	// Pending intersection, held until the next hit or end of scan
	always_ff @(posedge clk) begin
		if (ctl.ovl_take) begin
			pend_s_q <= ovl_s;
			pend_e_q <= ovl_e;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctl.emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			kind_q <= ctl.emit_kind;
			last_q <= ctl.emit_last;
			rs_q   <= ctl.emit_pend ? pend_s_q : '0;
			re_q   <= ctl.emit_pend ? pend_e_q : '0;
		end
	end

	assign valid       = valid_q;
	assign kind        = kind_q;
	assign range_start = rs_q;
	assign range_end   = re_q;
	assign last        = last_q;

	// Fill count never passes the table depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RANGES))
		else $error("entry count beyond table depth");

	// Overflow is only raised on a full table
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.set_ovf |-> cnt_q == CNT_W'(MAX_RANGES))
		else $error("overflow set with free slots");

	// A pending intersection is emitted only when one is held
	a_pend_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && ctl.emit_pend) |-> pend_v_q)
		else $error("pending range emitted while empty");

endmodule

// ----- src/referenced_range_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Referenced range tracker
// Table of byte ranges read by pending draws, with mark, query and clear.
// Clear, empty mark, and query on an empty or overflowed table: idle state
//   only, result on the next cycle, next transaction accepted at once.
// Mark: table RAM read of the last entry, then update in the mark state;
//   the result is registered from the update.
// Query scan: one RAM read per stored entry, up to the result cap;
//   overlaps stream out one per hit, the final one flagged by last.
// Results cannot be stalled. Reset clears the fill count and overflow flag;
//   table contents stay unwritten and are never used before being written.
// ----------------------------------------------------------------------------
module referenced_range_tracker_unit #(
	parameter int MAX_RANGES = rrt_pkg::MAX_RANGES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  cmd,
	input  logic [rrt_pkg::ADDR_W-1:0]  addr,
	input  logic [rrt_pkg::ADDR_W-1:0]  size,
	output logic                        valid,
	output logic [2:0]                  kind,
	output logic [rrt_pkg::END_W-1:0]   range_start,
	output logic [rrt_pkg::END_W-1:0]   range_end,
	output logic                        last
);

	rrt_pkg::ctl_t ctl;
	rrt_pkg::sts_t sts;

	rrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	rrt_dp #(
		.MAX_RANGES (MAX_RANGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.addr        (addr),
		.size        (size),
		.ctl         (ctl),
		.sts         (sts),
		.valid       (valid),
		.kind        (kind),
		.range_start (range_start),
		.range_end   (range_end),
		.last        (last)
	);

endmodule

// ----- tb/sv/tb_referenced_range_tracker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Referenced range tracker testbench
// Sends clear, mark and query commands through the start/busy handshake and
// keeps a shadow copy of the range table to predict every result. Strobed
// results are compared in order, field by field, against that prediction.
// Covers directed corner cases, a full table with overflow, and random traffic.
// ----------------------------------------------------------------------------
module tb_referenced_range_tracker_unit;

	localparam int          TBL_DEPTH  = rrt_pkg::MAX_RANGES_DEF;
	localparam logic [1:0]  CMD_UNUSED = 2'd3;
	localparam logic [32:0] TOP_ADDR33 = 33'h0_FFFF_FFFF;

	typedef struct {
		rrt_pkg::kind_t kind;
		logic [32:0]    rs;
		logic [32:0]    re;
		logic           last;
	} range_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	logic [31:0] addr;
	logic [31:0] size;
	logic        valid;
	logic [2:0]  kind;
	logic [32:0] range_start;
	logic [32:0] range_end;
	logic        last;

	// Shadow table and expected results
	logic [31:0] shadow_start [TBL_DEPTH];
	logic [32:0] shadow_end   [TBL_DEPTH];
	int          shadow_count;
	bit          shadow_ovf;
	range_res_t  exp_results [$];

	int err_cnt;
	int burst_left;

	referenced_range_tracker_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.addr       (addr),
		.size       (size),
		.valid      (valid),
		.kind       (kind),
		.range_start(range_start),
		.range_end  (range_end),
		.last       (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard limit on run time
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void flag_error(string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic void add_exp(rrt_pkg::kind_t k, logic [32:0] s, logic [32:0] e,
			logic l);
		range_res_t r;
		r.kind = k;
		r.rs   = s;
		r.re   = e;
		r.last = l;
		exp_results.push_back(r);
	endfunction

	// Update the shadow table for one accepted transaction and queue its results
	task automatic predict_ranges(input logic [1:0] c, input logic [31:0] a,
			input logic [31:0] s);
		logic [32:0] new_end;
		logic [32:0] lo;
		logic [32:0] hi;
		range_res_t  held;
		bit          have_held;
		int          hits;
		new_end   = {1'b0, a} + {1'b0, s};
		have_held = 1'b0;
		hits      = 0;
		case (c)
			rrt_pkg::CMD_CLEAR: begin
				shadow_count = 0;
				shadow_ovf   = 1'b0;
				add_exp(rrt_pkg::K_CLEARED, '0, '0, 1'b1);
			end
			rrt_pkg::CMD_MARK: begin
				if (s == 0) begin
					add_exp(rrt_pkg::K_EMPTY, '0, '0, 1'b1);
				end else if (shadow_count > 0 &&
						a >= shadow_start[shadow_count-1] &&
						{1'b0, a} <= shadow_end[shadow_count-1]) begin
					if (new_end > shadow_end[shadow_count-1])
						shadow_end[shadow_count-1] = new_end;
					add_exp(rrt_pkg::K_MERGED, '0, '0, 1'b1);
				end else if (shadow_count >= TBL_DEPTH) begin
					shadow_ovf = 1'b1;
					add_exp(rrt_pkg::K_OVERFLOW, '0, '0, 1'b1);
				end else begin
					shadow_start[shadow_count] = a;
					shadow_end[shadow_count]   = new_end;
					shadow_count++;
					add_exp(rrt_pkg::K_APPENDED, '0, '0, 1'b1);
				end
			end
			rrt_pkg::CMD_QUERY: begin
				if (shadow_ovf) begin
					add_exp(rrt_pkg::K_CONFLICT, '0, '0, 1'b1);
				end else begin
					// Intersections in table order, last flag on the final one
					for (int i = 0; i < shadow_count && hits < rrt_pkg::MAX_RESULTS;
							i++) begin
						lo = ({1'b0, shadow_start[i]} > {1'b0, a}) ?
							{1'b0, shadow_start[i]} : {1'b0, a};
						hi = (shadow_end[i] < new_end) ? shadow_end[i] : new_end;
						if (lo < hi) begin
							if (have_held)
								exp_results.push_back(held);
							held.kind = rrt_pkg::K_OVERLAP;
							held.rs   = lo;
							held.re   = hi;
							held.last = 1'b0;
							have_held = 1'b1;
							hits++;
						end
					end
					if (have_held) begin
						held.last = 1'b1;
						exp_results.push_back(held);
					end else begin
						add_exp(rrt_pkg::K_NONE, '0, '0, 1'b1);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Send one transaction; sender works in bursts with random gaps between
	task automatic send_txn(input logic [1:0] c, input logic [31:0] a,
			input logic [31:0] s);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = $urandom_range(1, 16);
			repeat (gap) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		cmd   <= c;
		addr  <= a;
		size  <= s;
		do @(posedge clk); while (busy);
		predict_ranges(c, a, s);
		burst_left--;
	endtask

	// Hold off the sender until every expected result has been seen
	task automatic drain_results;
		@(negedge clk);
		start <= 1'b0;
		while (exp_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_size();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1, 2, 3, 4: return $urandom_range(1, 256);
			5, 6, 7: return $urandom_range(1, 32'h0010_0000);
			8:       return $urandom;
			default: return 32'hFFFF_FFFF - $urandom_range(0, 15);
		endcase
	endfunction

	function automatic logic [31:0] rand_addr();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 32'h0010_0000 + $urandom_range(0, 32'h0004_0000);
			5:       return 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
			default: return $urandom;
		endcase
	endfunction

	// Start address inside the last table entry, so a mark merges
	function automatic logic [31:0] addr_in_last();
		logic [31:0] lo;
		logic [31:0] top;
		lo  = shadow_start[shadow_count-1];
		top = (shadow_end[shadow_count-1] > TOP_ADDR33) ? 32'hFFFF_FFFF :
			shadow_end[shadow_count-1][31:0];
		return $urandom_range(top, lo);
	endfunction

	// Result checker: every strobe must match the oldest expectation
	always @(posedge clk) begin : result_check
		range_res_t e;
		if (arst_n && valid) begin
			if (exp_results.size() == 0) begin
				flag_error($sformatf("unexpected result kind %0d start %h end %h last %0b",
					kind, range_start, range_end, last));
			end else begin
				e = exp_results.pop_front();
				if (kind !== e.kind || range_start !== e.rs || range_end !== e.re ||
						last !== e.last)
					flag_error($sformatf(
						"mismatch kind %0d/%0d start %h/%h end %h/%h last %0b/%0b (exp/got)",
						e.kind, kind, e.rs, range_start, e.re, range_end,
						e.last, last));
			end
		end
	end

	// Directed corner cases on a small table
	task automatic test_directed;
		send_txn(rrt_pkg::CMD_CLEAR, 32'h0, 32'h0);
		send_txn(rrt_pkg::CMD_QUERY, 32'h0, 32'hFFFF_FFFF);        // empty table
		send_txn(rrt_pkg::CMD_MARK, 32'h0000_2000, 32'h0);         // zero-size mark
		send_txn(rrt_pkg::CMD_MARK, 32'h0000_1000, 32'h100);       // append
		send_txn(rrt_pkg::CMD_MARK, 32'h0000_1080, 32'h10);        // merge, inside
		send_txn(rrt_pkg::CMD_MARK, 32'h0000_1100, 32'h100);       // merge at end
		send_txn(rrt_pkg::CMD_MARK, 32'h0000_3000, 32'h10);        // append
		send_txn(rrt_pkg::CMD_QUERY, 32'h0000_1100, 32'h0);        // zero-size query
		send_txn(rrt_pkg::CMD_QUERY, 32'h0000_10F0, 32'h2000);     // two overlaps
		send_txn(rrt_pkg::CMD_QUERY, 32'h0000_2000, 32'h100);      // gap, no overlap
		send_txn(rrt_pkg::CMD_QUERY, 32'h0000_1200, 32'h10);       // touches end only
		send_txn(rrt_pkg::CMD_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // end needs 33 bits
		send_txn(rrt_pkg::CMD_QUERY, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_txn(rrt_pkg::CMD_MARK, 32'hFFFF_FFFF, 32'h1);         // merge, no growth
		send_txn(rrt_pkg::CMD_QUERY, 32'h0, 32'hFFFF_FFFF);
		send_txn(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_txn(rrt_pkg::CMD_MARK, 32'h0, 32'h1);                 // append at zero
		send_txn(rrt_pkg::CMD_QUERY, 32'h0, 32'h1);
		send_txn(rrt_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_txn(rrt_pkg::CMD_QUERY, 32'h0000_1000, 32'h1000);     // after clear
	endtask

	// Fill every slot, query all of them, then drive past the end
	task automatic test_overflow;
		logic [31:0] a;
		send_txn(rrt_pkg::CMD_CLEAR, $urandom, $urandom);
		for (int i = 0; i < TBL_DEPTH; i++) begin
			a = 32'(i) * 32'h0800_0000 + $urandom_range(0, 32'h07F0_0000);
			send_txn(rrt_pkg::CMD_MARK, a, $urandom_range(1, 32'h0000_FFFF));
		end
		send_txn(rrt_pkg::CMD_QUERY, 32'h0, 32'hFFFF_FFFF);        // one per entry
		drain_results();
		send_txn(rrt_pkg::CMD_MARK, 32'h0100_0000, rand_size() | 32'h1);
		send_txn(rrt_pkg::CMD_MARK, addr_in_last(), rand_size());  // still merges
		repeat (3)
			send_txn(rrt_pkg::CMD_MARK, $urandom_range(0, 32'hF000_0000),
				$urandom_range(1, 64));
		send_txn(rrt_pkg::CMD_QUERY, $urandom, $urandom);
		send_txn(rrt_pkg::CMD_QUERY, $urandom, 32'h0);
		send_txn(rrt_pkg::CMD_MARK, $urandom, 32'h0);
		send_txn(rrt_pkg::CMD_CLEAR, 32'h0, 32'h0);
		send_txn(rrt_pkg::CMD_QUERY, $urandom, $urandom);
	endtask

	// Random traffic, mostly marks that cluster and queries near stored ranges
	task automatic test_random_traffic;
		int          pick;
		int          idx;
		logic [31:0] a;
		for (int n = 0; n < 140; n++) begin
			if (n == 70)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_txn(rrt_pkg::CMD_CLEAR, $urandom, $urandom);
			end else if (pick < 6) begin
				send_txn(CMD_UNUSED, $urandom, $urandom);
			end else if (pick < 38) begin
				send_txn(rrt_pkg::CMD_MARK, rand_addr(), rand_size());
			end else if (pick < 56) begin
				a = (shadow_count > 0) ? addr_in_last() : rand_addr();
				send_txn(rrt_pkg::CMD_MARK, a, rand_size());
			end else begin
				if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
					idx = $urandom_range(0, shadow_count - 1);
					a   = shadow_start[idx] - $urandom_range(0, 512);
				end else begin
					a = rand_addr();
				end
				send_txn(rrt_pkg::CMD_QUERY, a, rand_size());
			end
		end
	endtask

	initial begin
		err_cnt      = 0;
		burst_left   = 0;
		shadow_count = 0;
		shadow_ovf   = 1'b0;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = rrt_pkg::CMD_CLEAR;
		addr         = '0;
		size         = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_overflow();
		test_random_traffic();

		drain_results();
		repeat (2 * TBL_DEPTH + 8) @(posedge clk);
		if (exp_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", exp_results.size()));
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- referenced_range_tracker_unit.f -----
src/rrt_pkg.sv
src/rrt_ram.sv
src/rrt_ctrl.sv
src/rrt_dp.sv
src/referenced_range_tracker_unit.sv
tb/sv/tb_referenced_range_tracker_unit.sv
